// File: rtl/rational_arith_reduce_top_assert.svh
// Assertion macros for the rational arithmetic reduce block.
`ifndef RATIONAL_ARITH_REDUCE_TOP_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked property, off while reset is high.
`define RAR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rational_arith_reduce assertion failed");
// Checked property, also active during reset.
`define RAR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rational_arith_reduce assertion failed");
`else
`define RAR_ASSERT(lbl, clk, rst, prop)
`define RAR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/rar_pkg.sv
// Shared types and codes of the rational arithmetic reduce block.
`default_nettype none
package rar_pkg;
   // Action codes on the request side.
   localparam logic [2:0] ACT_REDUCE = 3'd0;
   localparam logic [2:0] ACT_ADD    = 3'd1;
   localparam logic [2:0] ACT_SUB    = 3'd2;
   localparam logic [2:0] ACT_MUL    = 3'd3;
   localparam logic [2:0] ACT_DIV    = 3'd4;
   localparam logic [2:0] ACT_NEG    = 3'd5;
   localparam logic [2:0] ACT_STEP   = 3'd6;

   // Classified operation codes carried to the back end.
   localparam logic [2:0] OP_REDUCE = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_SUB    = 3'd2;
   localparam logic [2:0] OP_MUL    = 3'd3;
   localparam logic [2:0] OP_DIV    = 3'd4;
   localparam logic [2:0] OP_NEG    = 3'd5;
   localparam logic [2:0] OP_INC    = 3'd6;
   localparam logic [2:0] OP_DEC    = 3'd7;

   typedef struct packed {
      logic [2:0]         op;
      logic               unary;
      logic signed [31:0] ln;
      logic signed [31:0] ld;
      logic signed [31:0] rn;
      logic signed [31:0] rd;
   } item_type;

   typedef struct packed {
      logic               start;
      logic signed [63:0] num;
      logic signed [63:0] den;
   } shr_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic signed [63:0] num;
      logic signed [63:0] den;
   } shr_rsp_type;
endpackage
`default_nettype wire

// File: rtl/rar_front.sv
// Front end: sign extends the parts and classifies the action.
`default_nettype none
module rar_front #(
   parameter int PART_WIDTH = 32
) (
   input  wire logic [2:0]  action,
   input  wire logic [31:0] left_num,
   input  wire logic [31:0] left_den,
   input  wire logic [31:0] right_num,
   input  wire logic [31:0] right_den,
   input  wire logic        step_down,
   output rar_pkg::item_type item
);
   localparam int SHIFT = 32 - PART_WIDTH;

   function automatic logic signed [31:0] part(input logic [31:0] raw);
      logic [31:0] up;
      up = raw << SHIFT;
      return $signed(up) >>> SHIFT;
   endfunction

   // Parts: low PART_WIDTH bits, sign extended; action decode, the unused
   // code behaves as reduce
   always_comb begin
      item.ln = part(left_num);
      item.ld = part(left_den);
      item.rn = part(right_num);
      item.rd = part(right_den);
      item.unary = 1'b1;
      case (action)
         rar_pkg::ACT_ADD: begin
            item.op = rar_pkg::OP_ADD;
            item.unary = 1'b0;
         end
         rar_pkg::ACT_SUB: begin
            item.op = rar_pkg::OP_SUB;
            item.unary = 1'b0;
         end
         rar_pkg::ACT_MUL: begin
            item.op = rar_pkg::OP_MUL;
            item.unary = 1'b0;
         end
         rar_pkg::ACT_DIV: begin
            item.op = rar_pkg::OP_DIV;
            item.unary = 1'b0;
         end
         rar_pkg::ACT_NEG:  item.op = rar_pkg::OP_NEG;
         rar_pkg::ACT_STEP: item.op = step_down ? rar_pkg::OP_DEC : rar_pkg::OP_INC;
         default:           item.op = rar_pkg::OP_REDUCE;
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/rar_queue.sv
// Two-entry queue between front and back end.
`default_nettype none
module rar_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire rar_pkg::item_type wr_item,
   output logic                   full,
   input  wire logic              rd_en,
   output rar_pkg::item_type      rd_item,
   output logic                   empty
);
   rar_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_wr;
   logic       do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_item = slot_ff[rd_ptr_ff];

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_wr) wr_ptr_ff <= !wr_ptr_ff;
         if (do_rd) rd_ptr_ff <= !rd_ptr_ff;
         if (do_wr && !do_rd)      count_ff <= count_ff + 2'd1;
         else if (do_rd && !do_wr) count_ff <= count_ff - 2'd1;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wr_ptr_ff] <= wr_item;
   end
endmodule
`default_nettype wire

// File: rtl/rar_shrink.sv
// Reduction unit: binary GCD of the magnitudes, then two restoring quotients.
`default_nettype none
module rar_shrink (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rar_pkg::shr_req_type req,
   output rar_pkg::shr_rsp_type      rsp
);
   localparam logic [1:0] SS_IDLE = 2'd0;
   localparam logic [1:0] SS_GCD  = 2'd1;
   localparam logic [1:0] SS_DIV  = 2'd2;

   logic [1:0]  state_ff;
   logic        done_ff;
   logic [63:0] a_ff, b_ff, g_ff;
   logic [5:0]  k_ff, cnt_ff;
   logic        neg_n_ff, neg_d_ff;
   logic [63:0] qn_ff, qd_ff, remn_ff, remd_ff;
   logic signed [63:0] num_ff, den_ff;

   logic [63:0] un, ud;
   logic [64:0] trial_n, trial_d;
   logic        bit_n, bit_d;
   logic [63:0] qn_in, qd_in;

   assign un = req.num[63] ? (64'd0 - req.num) : req.num;
   assign ud = req.den[63] ? (64'd0 - req.den) : req.den;

   // One restoring step for each quotient
   assign trial_n = {remn_ff, qn_ff[63]};
   assign trial_d = {remd_ff, qd_ff[63]};
   assign bit_n   = (trial_n >= {1'b0, g_ff});
   assign bit_d   = (trial_d >= {1'b0, g_ff});
   assign qn_in   = {qn_ff[62:0], bit_n};
   assign qd_in   = {qd_ff[62:0], bit_d};

   assign rsp.busy = (state_ff != SS_IDLE);
   assign rsp.done = done_ff;
   assign rsp.num  = num_ff;
   assign rsp.den  = den_ff;

   // Control sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            SS_IDLE: begin
               if (req.start) begin
                  if (un == 64'd0 && ud == 64'd0) done_ff <= 1'b1;
                  else state_ff <= SS_GCD;
               end
            end
            SS_GCD: begin
               if (a_ff == 64'd0 || b_ff == 64'd0) state_ff <= SS_DIV;
            end
            SS_DIV: begin
               if (cnt_ff == 6'd0) begin
                  state_ff <= SS_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: state_ff <= SS_IDLE;
         endcase
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         SS_IDLE: begin
            if (req.start) begin
               num_ff   <= req.num;
               den_ff   <= req.den;
               neg_n_ff <= req.num[63];
               neg_d_ff <= req.den[63];
               a_ff     <= un;
               b_ff     <= ud;
               qn_ff    <= un;
               qd_ff    <= ud;
               k_ff     <= 6'd0;
            end
         end
         SS_GCD: begin
            if (a_ff == 64'd0 || b_ff == 64'd0) begin
               g_ff    <= (a_ff | b_ff) << k_ff;
               remn_ff <= 64'd0;
               remd_ff <= 64'd0;
               cnt_ff  <= 6'd63;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_ff <= a_ff >> 1;
               b_ff <= b_ff >> 1;
               k_ff <= k_ff + 6'd1;
            end else if (!a_ff[0]) begin
               a_ff <= a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_ff <= b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_ff <= (a_ff - b_ff) >> 1;
            end else begin
               b_ff <= (b_ff - a_ff) >> 1;
            end
         end
         SS_DIV: begin
            remn_ff <= bit_n ? 64'(trial_n - {1'b0, g_ff}) : trial_n[63:0];
            remd_ff <= bit_d ? 64'(trial_d - {1'b0, g_ff}) : trial_d[63:0];
            qn_ff   <= qn_in;
            qd_ff   <= qd_in;
            cnt_ff  <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               num_ff <= neg_n_ff ? $signed(64'd0 - qn_in) : $signed(qn_in);
               den_ff <= neg_d_ff ? $signed(64'd0 - qd_in) : $signed(qd_in);
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/rar_back.sv
// Back end: reduces operands, forms products and sums, reduces the result.
`default_nettype none
module rar_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire rar_pkg::item_type    q_item,
   output logic                      q_pop,
   output rar_pkg::shr_req_type      shr_req,
   input  wire rar_pkg::shr_rsp_type shr_rsp,
   output logic                      empty,
   input  wire logic                 pop,
   output logic signed [63:0]        result_num,
   output logic signed [63:0]        result_den,
   output logic                      overflow
);
   localparam logic [2:0] BS_IDLE = 3'd0;
   localparam logic [2:0] BS_LSHR = 3'd1;
   localparam logic [2:0] BS_RSHR = 3'd2;
   localparam logic [2:0] BS_MULA = 3'd3;
   localparam logic [2:0] BS_MULB = 3'd4;
   localparam logic [2:0] BS_SUM  = 3'd5;
   localparam logic [2:0] BS_RES  = 3'd6;
   localparam logic [2:0] BS_OUT  = 3'd7;
   localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   logic [2:0]         state_ff;
   rar_pkg::item_type  item_ff;
   logic signed [63:0] ln_ff, ld_ff, rn_ff, rd_ff;
   logic signed [63:0] pa_ff, pb_ff, pden_ff;
   logic signed [63:0] rnum_ff, rden_ff;
   logic               rovf_ff, ovf_ff;
   logic               start_ff;
   logic signed [63:0] snum_ff, sden_ff;
   logic               out_valid_ff;
   logic signed [63:0] out_num_ff, out_den_ff;
   logic               out_ovf_ff;

   logic signed [32:0] x0, y0, x1, y1;
   logic signed [65:0] m0, m1;
   logic signed [64:0] s65;
   logic signed [63:0] sum_num;
   logic               sum_ovf;

   assign q_pop         = (state_ff == BS_IDLE) && !q_empty;
   assign shr_req.start = start_ff;
   assign shr_req.num   = snum_ff;
   assign shr_req.den   = sden_ff;
   assign empty         = !out_valid_ff;
   assign result_num    = out_num_ff;
   assign result_den    = out_den_ff;
   assign overflow      = out_ovf_ff;

   // Multiplier operand select: numerator pair, then denominator
   always_comb begin
      x0 = ln_ff[32:0];
      y0 = rd_ff[32:0];
      x1 = rn_ff[32:0];
      y1 = ld_ff[32:0];
      if (state_ff == BS_MULB) begin
         x0 = ld_ff[32:0];
         y0 = (item_ff.op == rar_pkg::OP_DIV) ? rn_ff[32:0] : rd_ff[32:0];
      end else if (item_ff.op == rar_pkg::OP_MUL) begin
         y0 = rn_ff[32:0];
      end
   end
   assign m0 = x0 * y0;
   assign m1 = x1 * y1;

   // Numerator forming with saturating sum
   always_comb begin
      s65     = 65'sd0;
      sum_ovf = 1'b0;
      case (item_ff.op)
         rar_pkg::OP_ADD, rar_pkg::OP_SUB: begin
            if (item_ff.op == rar_pkg::OP_ADD) s65 = {pa_ff[63], pa_ff} + {pb_ff[63], pb_ff};
            else                               s65 = {pa_ff[63], pa_ff} - {pb_ff[63], pb_ff};
            sum_ovf = (s65[64] != s65[63]);
            if (sum_ovf) sum_num = s65[64] ? S64_MIN : S64_MAX;
            else         sum_num = s65[63:0];
         end
         rar_pkg::OP_MUL, rar_pkg::OP_DIV: sum_num = pa_ff;
         rar_pkg::OP_NEG:                  sum_num = 64'sd0 - ln_ff;
         rar_pkg::OP_INC:                  sum_num = ln_ff + ld_ff;
         rar_pkg::OP_DEC:                  sum_num = ln_ff - ld_ff;
         default:                          sum_num = ln_ff;
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         start_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         // result transfer; the output state refills the register itself
         if (pop && out_valid_ff && state_ff != BS_OUT) out_valid_ff <= 1'b0;
         case (state_ff)
            BS_IDLE: begin
               if (!q_empty) begin
                  start_ff <= 1'b1;
                  state_ff <= BS_LSHR;
               end
            end
            BS_LSHR: begin
               if (shr_rsp.done) begin
                  if (item_ff.unary) begin
                     state_ff <= BS_SUM;
                  end else begin
                     start_ff <= 1'b1;
                     state_ff <= BS_RSHR;
                  end
               end
            end
            BS_RSHR: if (shr_rsp.done) state_ff <= BS_MULA;
            BS_MULA: state_ff <= BS_MULB;
            BS_MULB: state_ff <= BS_SUM;
            BS_SUM: begin
               start_ff <= 1'b1;
               state_ff <= BS_RES;
            end
            BS_RES: if (shr_rsp.done) state_ff <= BS_OUT;
            BS_OUT: begin
               if (!out_valid_ff || pop) begin
                  out_valid_ff <= 1'b1;
                  state_ff     <= BS_IDLE;
               end
            end
            default: state_ff <= BS_IDLE;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         BS_IDLE: begin
            item_ff <= q_item;
            snum_ff <= 64'(q_item.ln);
            sden_ff <= 64'(q_item.ld);
            ovf_ff  <= 1'b0;
         end
         BS_LSHR: begin
            if (shr_rsp.done) begin
               ln_ff   <= shr_rsp.num;
               ld_ff   <= shr_rsp.den;
               snum_ff <= 64'(item_ff.rn);
               sden_ff <= 64'(item_ff.rd);
            end
         end
         BS_RSHR: begin
            if (shr_rsp.done) begin
               rn_ff <= shr_rsp.num;
               rd_ff <= shr_rsp.den;
            end
         end
         BS_MULA: begin
            pa_ff <= m0[63:0];
            pb_ff <= m1[63:0];
         end
         BS_MULB: pden_ff <= m0[63:0];
         BS_SUM: begin
            snum_ff <= sum_num;
            sden_ff <= item_ff.unary ? ld_ff : pden_ff;
            ovf_ff  <= sum_ovf;
         end
         BS_RES: begin
            if (shr_rsp.done) begin
               rnum_ff <= shr_rsp.num;
               rden_ff <= shr_rsp.den;
               rovf_ff <= ovf_ff;
            end
         end
         BS_OUT: begin
            if (!out_valid_ff || pop) begin
               out_num_ff <= rnum_ff;
               out_den_ff <= rden_ff;
               out_ovf_ff <= rovf_ff;
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/rational_arith_reduce_top.sv
// Top level of the rational arithmetic reduce block.
// Usage:
//  Requests enter as a queue: drive push with the action, two fractions and
//  step_down; a transfer happens on a clock edge with push high, full low.
//  A two-entry queue holds requests while the back end is busy.
//  Results leave as a queue: while empty is low the oldest result sits on the
//  rsp_ ports; a transfer happens on a clock edge with pop high, empty low.
//  Each item runs up to three passes through one shared reduction unit
//  (left operand, right operand, result); unary actions skip the right pass.
//  A pass is a binary GCD at one subtract or shift per cycle and a
//  restoring quotient; a both-zero pass skips both and completes from idle.
//  The back end holds one item at a time and pops the next only after the
//  result of the last has moved to the result register.
//  Reset (synchronous, active high) empties both queues and idles the unit.
//  A stalled receiver holds the result register; the back end finishes the
//  next item and waits, and requests then back up into the front queue.
`default_nettype none
`include "rational_arith_reduce_top_assert.svh"
module rational_arith_reduce_top #(
   parameter int PART_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [2:0]         req_action,
   input  wire logic [31:0]        req_left_num,
   input  wire logic [31:0]        req_left_den,
   input  wire logic [31:0]        req_right_num,
   input  wire logic [31:0]        req_right_den,
   input  wire logic               req_step_down,
   output logic                    empty,
   input  wire logic               pop,
   output logic signed [63:0]      rsp_result_num,
   output logic signed [63:0]      rsp_result_den,
   output logic                    rsp_overflow
);
   rar_pkg::item_type    front_item;
   rar_pkg::item_type    q_item;
   logic                 q_empty;
   logic                 q_pop;
   rar_pkg::shr_req_type shr_req;
   rar_pkg::shr_rsp_type shr_rsp;

   rar_front #(.PART_WIDTH(PART_WIDTH)) u_front (
      .action    (req_action),
      .left_num  (req_left_num),
      .left_den  (req_left_den),
      .right_num (req_right_num),
      .right_den (req_right_den),
      .step_down (req_step_down),
      .item      (front_item)
   );

   rar_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_item (front_item),
      .full    (full),
      .rd_en   (q_pop),
      .rd_item (q_item),
      .empty   (q_empty)
   );

   rar_shrink u_shrink (
      .clock (clock),
      .reset (reset),
      .req   (shr_req),
      .rsp   (shr_rsp)
   );

   rar_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .shr_req    (shr_req),
      .shr_rsp    (shr_rsp),
      .empty      (empty),
      .pop        (pop),
      .result_num (rsp_result_num),
      .result_den (rsp_result_den),
      .overflow   (rsp_overflow)
   );

   // Reduction unit is only started when idle
   `RAR_ASSERT(a_start_idle, clock, reset, shr_req.start |-> !shr_rsp.busy)
   // Completion is a single-cycle pulse
   `RAR_ASSERT(a_done_pulse, clock, reset, shr_rsp.done |=> !shr_rsp.done)
   // Back end never pops an empty queue
   `RAR_ASSERT_ALWAYS(a_pop_nonempty, clock, q_pop |-> !q_empty)
endmodule
`default_nettype wire
